// ===== sv/slwl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwl_pkg
// Shared types, codes and defaults of the per-source sliding-window limiter.
// ----------------------------------------------------------------------------
package slwl_pkg;

  localparam int DEF_SOURCE_SLOTS = 64;
  localparam int DEF_USER_SLOTS   = 64;
  localparam int DEF_LOGIN_RING   = 32;
  localparam int DEF_COMMAND_RING = 256;
  localparam int DEF_KICK_RING    = 16;

  localparam logic [31:0] LOGIN_WINDOW   = 32'd60;
  localparam logic [31:0] COMMAND_WINDOW = 32'd60;
  localparam logic [31:0] KICK_WINDOW    = 32'd900;
  localparam int          KB_SHIFT       = 10;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_OPEN   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_CMDS   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_KB     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LOGINS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_KICK_BAN   = 3'd4;

  localparam logic [7:0]  RST_MAX_OPEN   = 8'd5;
  localparam logic [8:0]  RST_MAX_CMDS   = 9'd200;
  localparam logic [11:0] RST_MAX_KB     = 12'd40;
  localparam logic [5:0]  RST_MAX_LOGINS = 6'd20;
  localparam logic [4:0]  RST_KICK_BAN   = 5'd10;

  localparam logic [1:0] ACT_CONNECT    = 2'd0;
  localparam logic [1:0] ACT_DISCONNECT = 2'd1;
  localparam logic [1:0] ACT_TRANSFER   = 2'd2;

  localparam logic [2:0] CAUSE_NONE       = 3'd0;
  localparam logic [2:0] CAUSE_LOGIN_RATE = 3'd1;
  localparam logic [2:0] CAUSE_OPEN_LIMIT = 3'd2;
  localparam logic [2:0] CAUSE_CMD_COUNT  = 3'd3;
  localparam logic [2:0] CAUSE_BYTE_VOL   = 3'd4;
  localparam logic [2:0] CAUSE_OVERSIZE   = 3'd5;
  localparam logic [2:0] CAUSE_TABLE_FULL = 3'd6;

  typedef enum logic [1:0] {
    KIND_CONNECT    = 2'd0,
    KIND_DISCONNECT = 2'd1,
    KIND_TRANSFER   = 2'd2,
    KIND_NONE       = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] source_addr;
    logic [15:0] user_id;
    logic [19:0] transfer_bytes;
    logic [31:0] now_seconds;
  } item_t;

  typedef struct packed {
    logic       allowed;
    logic [2:0] deny_cause;
    logic       kick_user;
    logic       ban_source;
  } result_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] source_addr;
    logic [15:0] user_id;
    logic [19:0] transfer_bytes;
    logic [31:0] now_seconds;
  } work_t;

  typedef struct packed {
    logic [7:0]  max_open;
    logic [8:0]  max_cmds;
    logic [11:0] max_kb;
    logic [5:0]  max_logins;
    logic [4:0]  kick_ban;
  } cfg_t;

endpackage

// ===== sv/slwl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwl_front
// Input queue: accepts event words, classifies the action and buffers two.
// ----------------------------------------------------------------------------
module slwl_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            hold,
  input  logic            push,
  input  slwl_pkg::item_t item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output slwl_pkg::work_t work
);
  import slwl_pkg::*;

  work_t      ent [2];
  work_t      cls;
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       acc;
  logic       deq;

  assign full  = hold || (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign acc   = push && !full;
  assign deq   = pop && !empty;
  assign work  = ent[rp];

  always_comb begin
    cls.source_addr    = item.source_addr;
    cls.user_id        = item.user_id;
    cls.transfer_bytes = item.transfer_bytes;
    cls.now_seconds    = item.now_seconds;
    case (item.action)
      ACT_CONNECT:    cls.kind = KIND_CONNECT;
      ACT_DISCONNECT: cls.kind = KIND_DISCONNECT;
      ACT_TRANSFER:   cls.kind = KIND_TRANSFER;
      default:        cls.kind = KIND_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (acc) wp <= ~wp;
      if (deq) rp <= ~rp;
      cnt <= cnt + 2'(acc) - 2'(deq);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) ent[wp] <= cls;
  end

endmodule

// ===== sv/slwl_resq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwl_resq
// Result queue: two-entry buffer between the engine and the result port.
// ----------------------------------------------------------------------------
module slwl_resq (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  slwl_pkg::result_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output slwl_pkg::result_t result
);
  import slwl_pkg::*;

  result_t    ent [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       acc;
  logic       deq;

  assign full   = (cnt == 2'd2);
  assign empty  = (cnt == 2'd0);
  assign acc    = wr && !full;
  assign deq    = pop && !empty;
  assign result = ent[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (acc) wp <= ~wp;
      if (deq) rp <= ~rp;
      cnt <= cnt + 2'(acc) - 2'(deq);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) ent[wp] <= wdata;
  end

endmodule

// ===== sv/slwl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwl_back
// Engine: table scans, log pruning and decisions, one event word at a time.
// ----------------------------------------------------------------------------
module slwl_back #(
  parameter int SOURCE_SLOTS = slwl_pkg::DEF_SOURCE_SLOTS,
  parameter int USER_SLOTS   = slwl_pkg::DEF_USER_SLOTS,
  parameter int LOGIN_RING   = slwl_pkg::DEF_LOGIN_RING,
  parameter int COMMAND_RING = slwl_pkg::DEF_COMMAND_RING,
  parameter int KICK_RING    = slwl_pkg::DEF_KICK_RING
) (
  input  logic              clk,
  input  logic              rst,
  input  slwl_pkg::cfg_t    cfg,
  input  logic              q_empty,
  input  slwl_pkg::work_t   q_work,
  output logic              q_pop,
  input  logic              oq_full,
  output logic              oq_push,
  output slwl_pkg::result_t oq_data,
  output logic              clearing
);
  import slwl_pkg::*;

  localparam int SAW   = $clog2(SOURCE_SLOTS);
  localparam int UAW   = $clog2(USER_SLOTS);
  localparam int LHW   = (LOGIN_RING > 1) ? $clog2(LOGIN_RING) : 1;
  localparam int LFW   = $clog2(LOGIN_RING + 1);
  localparam int KHW   = (KICK_RING > 1) ? $clog2(KICK_RING) : 1;
  localparam int KFW   = $clog2(KICK_RING + 1);
  localparam int CHW   = (COMMAND_RING > 1) ? $clog2(COMMAND_RING) : 1;
  localparam int CFW   = $clog2(COMMAND_RING + 1);
  localparam int LAW   = $clog2(SOURCE_SLOTS * LOGIN_RING);
  localparam int KAW   = $clog2(SOURCE_SLOTS * KICK_RING);
  localparam int CAW   = $clog2(USER_SLOTS * COMMAND_RING);
  localparam int CLR_N = (SOURCE_SLOTS > USER_SLOTS) ? SOURCE_SLOTS : USER_SLOTS;
  localparam int CLW   = $clog2(CLR_N);

  typedef struct packed {
    logic           valid;
    logic [31:0]    tag;
    logic [7:0]     open_cnt;
    logic [LHW-1:0] lhead;
    logic [LFW-1:0] lfill;
    logic [KHW-1:0] khead;
    logic [KFW-1:0] kfill;
  } smeta_t;

  typedef struct packed {
    logic           valid;
    logic [15:0]    tag;
    logic [CHW-1:0] chead;
    logic [CFW-1:0] cfill;
    logic [23:0]    btotal;
  } umeta_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [19:0] len;
  } cmd_t;

  typedef enum logic [16:0] {
    ST_CLEAR      = 17'h00001,
    ST_IDLE       = 17'h00002,
    ST_SRC_RD     = 17'h00004,
    ST_SRC_CHK    = 17'h00008,
    ST_SRC_LOG    = 17'h00010,
    ST_SRC_LOGCHK = 17'h00020,
    ST_SRC_DONE   = 17'h00040,
    ST_LP_RD      = 17'h00080,
    ST_LP_CHK     = 17'h00100,
    ST_KP_RD      = 17'h00200,
    ST_KP_CHK     = 17'h00400,
    ST_USR_RD     = 17'h00800,
    ST_USR_CHK    = 17'h01000,
    ST_USR_DONE   = 17'h02000,
    ST_CP_RD      = 17'h04000,
    ST_CP_CHK     = 17'h08000,
    ST_RESULT     = 17'h10000
  } state_e;

  function automatic logic [31:0] wrap(input logic [31:0] v, input logic [31:0] n);
    return (v >= n) ? (v - n) : v;
  endfunction

  function automatic logic expired(input logic [31:0] now_s, input logic [31:0] t,
                                   input logic [31:0] win);
    return (now_s - t) > win;
  endfunction

  smeta_t      src_mem   [SOURCE_SLOTS];
  umeta_t      usr_mem   [USER_SLOTS];
  logic [31:0] login_mem [SOURCE_SLOTS * LOGIN_RING];
  logic [31:0] kick_mem  [SOURCE_SLOTS * KICK_RING];
  cmd_t        cmd_mem   [USER_SLOTS * COMMAND_RING];

  smeta_t      src_rdata;
  umeta_t      usr_rdata;
  logic [31:0] login_rdata;
  logic [31:0] kick_rdata;
  cmd_t        cmd_rdata;

  state_e         state;
  logic [CLW-1:0] clr_i;
  work_t          work;
  logic [SAW-1:0] src_i;
  logic [SAW-1:0] slot;
  logic [SAW-1:0] c_slot;
  logic           s_hit;
  logic           c_have;
  logic [UAW-1:0] usr_i;
  logic [UAW-1:0] uslot;
  logic [UAW-1:0] f_slot;
  logic           u_hit;
  logic           f_have;
  smeta_t         sm;
  umeta_t         um;
  result_t        res;

  logic [21:0]    byte_limit;
  logic           lp_expire;
  logic           conn_ok;
  logic           login_full;
  logic           open_full;
  logic           kp_expire;
  logic           ban_hit;
  smeta_t         sm_kick;
  logic           cp_expire;
  logic           cmd_full;
  logic           byte_over;
  logic           new_over;
  logic           stale_log;

  logic [LAW-1:0] login_raddr;
  logic [KAW-1:0] kick_raddr;
  logic [CAW-1:0] cmd_raddr;

  logic           src_we;
  logic [SAW-1:0] src_waddr;
  smeta_t         src_wdata;
  logic           usr_we;
  logic [UAW-1:0] usr_waddr;
  umeta_t         usr_wdata;
  logic           login_we;
  logic [LAW-1:0] login_waddr;
  logic           kick_we;
  logic [KAW-1:0] kick_waddr;
  logic           cmd_we;
  logic [CAW-1:0] cmd_waddr;
  cmd_t           cmd_wdata;

  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign oq_push  = (state == ST_RESULT) && !oq_full;
  assign oq_data  = res;
  assign clearing = (state == ST_CLEAR);

  always_comb begin
    byte_limit = {cfg.max_kb, {KB_SHIFT{1'b0}}};
    lp_expire  = (sm.lfill != '0) && expired(work.now_seconds, login_rdata, LOGIN_WINDOW);
    login_full = (32'(sm.lfill) >= 32'(cfg.max_logins)) || (32'(sm.lfill) >= LOGIN_RING);
    open_full  = sm.open_cnt >= cfg.max_open;
    conn_ok    = !login_full && !open_full;
    kp_expire  = (sm.kfill != '0) && expired(work.now_seconds, kick_rdata, KICK_WINDOW);
    ban_hit    = (32'(sm.kfill) >= 32'(cfg.kick_ban)) || (32'(sm.kfill) >= KICK_RING);
    sm_kick    = sm;
    if (32'(sm.kfill) == KICK_RING) begin
      sm_kick.khead = KHW'(wrap(32'(sm.khead) + 32'd1, KICK_RING));
      sm_kick.kfill = sm.kfill - KFW'(1);
    end
    cp_expire  = (um.cfill != '0) &&
                 expired(work.now_seconds, cmd_rdata.stamp, COMMAND_WINDOW);
    cmd_full   = (32'(um.cfill) >= 32'(cfg.max_cmds)) || (32'(um.cfill) >= COMMAND_RING);
    byte_over  = (25'(um.btotal) + 25'(work.transfer_bytes)) > 25'(byte_limit);
    new_over   = 22'(work.transfer_bytes) > byte_limit;
    stale_log  = ((sm.lfill == '0) || expired(work.now_seconds, login_rdata, LOGIN_WINDOW))
              && ((sm.kfill == '0) || expired(work.now_seconds, kick_rdata, KICK_WINDOW));
  end

  always_comb begin
    if (state == ST_SRC_LOG) begin
      login_raddr = LAW'(32'(src_i) * LOGIN_RING +
                         wrap(32'(sm.lhead) + 32'(sm.lfill) - 32'd1, LOGIN_RING));
      kick_raddr  = KAW'(32'(src_i) * KICK_RING +
                         wrap(32'(sm.khead) + 32'(sm.kfill) - 32'd1, KICK_RING));
    end else begin
      login_raddr = LAW'(32'(slot) * LOGIN_RING + 32'(sm.lhead));
      kick_raddr  = KAW'(32'(slot) * KICK_RING + 32'(sm.khead));
    end
    cmd_raddr = CAW'(32'(uslot) * COMMAND_RING + 32'(um.chead));
  end

  always_comb begin
    src_we      = 1'b0;
    src_waddr   = slot;
    src_wdata   = sm;
    usr_we      = 1'b0;
    usr_waddr   = uslot;
    usr_wdata   = um;
    login_we    = 1'b0;
    login_waddr = LAW'(32'(slot) * LOGIN_RING +
                       wrap(32'(sm.lhead) + 32'(sm.lfill), LOGIN_RING));
    kick_we     = 1'b0;
    kick_waddr  = KAW'(32'(slot) * KICK_RING +
                       wrap(32'(sm_kick.khead) + 32'(sm_kick.kfill), KICK_RING));
    cmd_we      = 1'b0;
    cmd_waddr   = CAW'(32'(uslot) * COMMAND_RING +
                       wrap(32'(um.chead) + 32'(um.cfill), COMMAND_RING));
    cmd_wdata   = '{stamp: work.now_seconds, len: work.transfer_bytes};
    case (state)
      ST_CLEAR: begin
        src_we    = 32'(clr_i) < SOURCE_SLOTS;
        src_waddr = clr_i[SAW-1:0];
        src_wdata = '0;
        usr_we    = 32'(clr_i) < USER_SLOTS;
        usr_waddr = clr_i[UAW-1:0];
        usr_wdata = '0;
      end
      ST_SRC_DONE: begin
        if (work.kind == KIND_DISCONNECT && s_hit) begin
          src_we = 1'b1;
          if (sm.open_cnt != 8'd0) src_wdata.open_cnt = sm.open_cnt - 8'd1;
        end
      end
      ST_LP_CHK: begin
        if (!lp_expire) begin
          src_we = 1'b1;
          if (conn_ok) begin
            src_wdata.lfill    = sm.lfill + LFW'(1);
            src_wdata.open_cnt = sm.open_cnt + 8'd1;
            login_we           = 1'b1;
          end
        end
      end
      ST_KP_CHK: begin
        if (!kp_expire) begin
          src_we          = 1'b1;
          src_wdata       = sm_kick;
          src_wdata.kfill = sm_kick.kfill + KFW'(1);
          kick_we         = 1'b1;
        end
      end
      ST_USR_DONE: begin
        if (work.kind == KIND_DISCONNECT) begin
          usr_we    = u_hit;
          usr_wdata = '0;
        end else if (!u_hit && !new_over && f_have) begin
          usr_we    = 1'b1;
          usr_waddr = f_slot;
          usr_wdata = '{valid: 1'b1, tag: work.user_id, chead: '0, cfill: CFW'(1),
                        btotal: 24'(work.transfer_bytes)};
          cmd_we    = 1'b1;
          cmd_waddr = CAW'(32'(f_slot) * COMMAND_RING);
        end
      end
      ST_CP_CHK: begin
        if (!cp_expire) begin
          usr_we = 1'b1;
          if (!cmd_full && !byte_over) begin
            usr_wdata.cfill  = um.cfill + CFW'(1);
            usr_wdata.btotal = um.btotal + 24'(work.transfer_bytes);
            cmd_we           = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (src_we) src_mem[src_waddr] <= src_wdata;
    src_rdata <= src_mem[src_i];
  end

  always_ff @(posedge clk) begin
    if (usr_we) usr_mem[usr_waddr] <= usr_wdata;
    usr_rdata <= usr_mem[usr_i];
  end

  always_ff @(posedge clk) begin
    if (login_we) login_mem[login_waddr] <= work.now_seconds;
    login_rdata <= login_mem[login_raddr];
  end

  always_ff @(posedge clk) begin
    if (kick_we) kick_mem[kick_waddr] <= work.now_seconds;
    kick_rdata <= kick_mem[kick_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd_we) cmd_mem[cmd_waddr] <= cmd_wdata;
    cmd_rdata <= cmd_mem[cmd_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_i <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_i <= clr_i + CLW'(1);
          if (clr_i == CLW'(CLR_N - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (!q_empty) begin
            work   <= q_work;
            res    <= '0;
            src_i  <= '0;
            s_hit  <= 1'b0;
            c_have <= 1'b0;
            usr_i  <= '0;
            u_hit  <= 1'b0;
            f_have <= 1'b0;
            case (q_work.kind)
              KIND_CONNECT, KIND_DISCONNECT: state <= ST_SRC_RD;
              KIND_TRANSFER:                 state <= ST_USR_RD;
              default:                       state <= ST_RESULT;
            endcase
          end
        end
        ST_SRC_RD: state <= ST_SRC_CHK;
        ST_SRC_CHK: begin
          sm <= src_rdata;
          if (src_rdata.valid && src_rdata.tag == work.source_addr) begin
            s_hit <= 1'b1;
            slot  <= src_i;
            state <= ST_SRC_DONE;
          end else if (!c_have && src_rdata.valid && src_rdata.open_cnt == 8'd0 &&
                       (src_rdata.lfill != '0 || src_rdata.kfill != '0)) begin
            state <= ST_SRC_LOG;
          end else begin
            if (!c_have && (!src_rdata.valid || src_rdata.open_cnt == 8'd0)) begin
              c_have <= 1'b1;
              c_slot <= src_i;
            end
            if (src_i == SAW'(SOURCE_SLOTS - 1)) begin
              state <= ST_SRC_DONE;
            end else begin
              src_i <= src_i + SAW'(1);
              state <= ST_SRC_RD;
            end
          end
        end
        ST_SRC_LOG: state <= ST_SRC_LOGCHK;
        ST_SRC_LOGCHK: begin
          if (stale_log) begin
            c_have <= 1'b1;
            c_slot <= src_i;
          end
          if (src_i == SAW'(SOURCE_SLOTS - 1)) begin
            state <= ST_SRC_DONE;
          end else begin
            src_i <= src_i + SAW'(1);
            state <= ST_SRC_RD;
          end
        end
        ST_SRC_DONE: begin
          if (work.kind == KIND_DISCONNECT) begin
            usr_i  <= '0;
            u_hit  <= 1'b0;
            f_have <= 1'b0;
            state  <= ST_USR_RD;
          end else if (s_hit) begin
            state <= (work.kind == KIND_CONNECT) ? ST_LP_RD : ST_KP_RD;
          end else if (c_have) begin
            slot  <= c_slot;
            sm    <= '{valid: 1'b1, tag: work.source_addr, open_cnt: 8'd0,
                       lhead: '0, lfill: '0, khead: '0, kfill: '0};
            state <= (work.kind == KIND_CONNECT) ? ST_LP_RD : ST_KP_RD;
          end else begin
            if (work.kind == KIND_CONNECT) res.deny_cause <= CAUSE_TABLE_FULL;
            state <= ST_RESULT;
          end
        end
        ST_LP_RD: state <= ST_LP_CHK;
        ST_LP_CHK: begin
          if (lp_expire) begin
            sm.lhead <= LHW'(wrap(32'(sm.lhead) + 32'd1, LOGIN_RING));
            sm.lfill <= sm.lfill - LFW'(1);
            state    <= ST_LP_RD;
          end else begin
            if (login_full)     res.deny_cause <= CAUSE_LOGIN_RATE;
            else if (open_full) res.deny_cause <= CAUSE_OPEN_LIMIT;
            else                res.allowed    <= 1'b1;
            state <= ST_RESULT;
          end
        end
        ST_KP_RD: state <= ST_KP_CHK;
        ST_KP_CHK: begin
          if (kp_expire) begin
            sm.khead <= KHW'(wrap(32'(sm.khead) + 32'd1, KICK_RING));
            sm.kfill <= sm.kfill - KFW'(1);
            state    <= ST_KP_RD;
          end else begin
            res.ban_source <= ban_hit;
            state          <= ST_RESULT;
          end
        end
        ST_USR_RD: state <= ST_USR_CHK;
        ST_USR_CHK: begin
          um <= usr_rdata;
          if (usr_rdata.valid && usr_rdata.tag == work.user_id) begin
            u_hit <= 1'b1;
            uslot <= usr_i;
            state <= ST_USR_DONE;
          end else begin
            if (!usr_rdata.valid && !f_have) begin
              f_have <= 1'b1;
              f_slot <= usr_i;
            end
            if (usr_i == UAW'(USER_SLOTS - 1)) begin
              state <= ST_USR_DONE;
            end else begin
              usr_i <= usr_i + UAW'(1);
              state <= ST_USR_RD;
            end
          end
        end
        ST_USR_DONE: begin
          if (work.kind == KIND_DISCONNECT) begin
            res.allowed <= 1'b1;
            state       <= ST_RESULT;
          end else if (u_hit) begin
            state <= ST_CP_RD;
          end else if (new_over) begin
            res.deny_cause <= CAUSE_OVERSIZE;
            res.kick_user  <= 1'b1;
            state          <= ST_SRC_RD;
          end else if (!f_have) begin
            res.deny_cause <= CAUSE_TABLE_FULL;
            state          <= ST_RESULT;
          end else begin
            res.allowed <= 1'b1;
            state       <= ST_RESULT;
          end
        end
        ST_CP_RD: state <= ST_CP_CHK;
        ST_CP_CHK: begin
          if (cp_expire) begin
            um.btotal <= um.btotal - 24'(cmd_rdata.len);
            um.chead  <= CHW'(wrap(32'(um.chead) + 32'd1, COMMAND_RING));
            um.cfill  <= um.cfill - CFW'(1);
            state     <= ST_CP_RD;
          end else if (cmd_full) begin
            res.deny_cause <= CAUSE_CMD_COUNT;
            res.kick_user  <= 1'b1;
            state          <= ST_SRC_RD;
          end else if (byte_over) begin
            res.deny_cause <= CAUSE_BYTE_VOL;
            res.kick_user  <= 1'b1;
            state          <= ST_SRC_RD;
          end else begin
            res.allowed <= 1'b1;
            state       <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!oq_full) state <= ST_IDLE;
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

endmodule

// ===== sv/per_source_sliding_window_limiter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_source_sliding_window_limiter_top
// Connection and transfer limiter with per-address and per-user sliding logs.
// Timing: set by the engine's table scans, a read and a check per source slot
//   (and per newest-log read), per user slot and per pruned entry.
// Throughput: one event at a time in the engine; two queue ahead, two behind.
// Reset: a clearing pass zeroes the address and user tables; full is high.
// ----------------------------------------------------------------------------
module per_source_sliding_window_limiter_top #(
  parameter int SOURCE_SLOTS = slwl_pkg::DEF_SOURCE_SLOTS,
  parameter int USER_SLOTS   = slwl_pkg::DEF_USER_SLOTS,
  parameter int LOGIN_RING   = slwl_pkg::DEF_LOGIN_RING,
  parameter int COMMAND_RING = slwl_pkg::DEF_COMMAND_RING,
  parameter int KICK_RING    = slwl_pkg::DEF_KICK_RING
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  slwl_pkg::item_t                  item,
  output logic                             full,
  input  logic                             pop,
  output logic                             empty,
  output slwl_pkg::result_t                result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [slwl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [slwl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import slwl_pkg::*;

  cfg_t    cfg;
  logic    q_empty;
  work_t   q_work;
  logic    q_pop;
  logic    oq_full;
  logic    oq_push;
  result_t oq_data;
  logic    clearing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_open   <= RST_MAX_OPEN;
      cfg.max_cmds   <= RST_MAX_CMDS;
      cfg.max_kb     <= RST_MAX_KB;
      cfg.max_logins <= RST_MAX_LOGINS;
      cfg.kick_ban   <= RST_KICK_BAN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_OPEN:   cfg.max_open   <= cfg_data[7:0];
        CFG_MAX_CMDS:   cfg.max_cmds   <= cfg_data[8:0];
        CFG_MAX_KB:     cfg.max_kb     <= cfg_data[11:0];
        CFG_MAX_LOGINS: cfg.max_logins <= cfg_data[5:0];
        CFG_KICK_BAN:   cfg.kick_ban   <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  slwl_front u_front (
    .clk   (clk),
    .rst   (rst),
    .hold  (clearing),
    .push  (push),
    .item  (item),
    .full  (full),
    .pop   (q_pop),
    .empty (q_empty),
    .work  (q_work)
  );

  slwl_back #(
    .SOURCE_SLOTS (SOURCE_SLOTS),
    .USER_SLOTS   (USER_SLOTS),
    .LOGIN_RING   (LOGIN_RING),
    .COMMAND_RING (COMMAND_RING),
    .KICK_RING    (KICK_RING)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_work   (q_work),
    .q_pop    (q_pop),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .oq_data  (oq_data),
    .clearing (clearing)
  );

  slwl_resq u_resq (
    .clk    (clk),
    .rst    (rst),
    .wr     (oq_push),
    .wdata  (oq_data),
    .full   (oq_full),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  a_allow_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.allowed) |-> (result.deny_cause == CAUSE_NONE && !result.kick_user))
    else $error("allowed word carries a cause or kick");

  a_kick_cause: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kick_user) |-> (result.deny_cause == CAUSE_CMD_COUNT ||
      result.deny_cause == CAUSE_BYTE_VOL || result.deny_cause == CAUSE_OVERSIZE))
    else $error("kick without a transfer refusal cause");

  a_ban_kick: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.ban_source) |-> result.kick_user)
    else $error("ban flag without kick");

  a_clear_hold: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (full && !oq_push))
    else $error("input open or result produced during clearing pass");

endmodule

// ===== tb/sv/slwl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwl_checker
// Watches the event, result and register channels of the limiter, keeps its
// own copy of the address and user tables, predicts each decision word and
// compares it with the word that the block returns.
// ----------------------------------------------------------------------------
module slwl_checker #(
  parameter int SRC_N  = slwl_pkg::DEF_SOURCE_SLOTS,
  parameter int USR_N  = slwl_pkg::DEF_USER_SLOTS,
  parameter int LOG_N  = slwl_pkg::DEF_LOGIN_RING,
  parameter int CMD_N  = slwl_pkg::DEF_COMMAND_RING,
  parameter int KICK_N = slwl_pkg::DEF_KICK_RING
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic                             full,
  input  slwl_pkg::item_t                  item,
  input  logic                             pop,
  input  logic                             empty,
  input  slwl_pkg::result_t                result,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [slwl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [slwl_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               errors,
  output int                               pending
);
  import slwl_pkg::*;

  cfg_t         limits;
  logic [31:0]  src_tag   [SRC_N];
  bit           src_used  [SRC_N];
  int unsigned  opens     [SRC_N];
  logic [31:0]  login_at  [SRC_N][LOG_N];
  int unsigned  login_hd  [SRC_N];
  int unsigned  login_n   [SRC_N];
  logic [31:0]  kick_at   [SRC_N][KICK_N];
  int unsigned  kick_hd   [SRC_N];
  int unsigned  kick_n    [SRC_N];
  logic [15:0]  usr_tag   [USR_N];
  bit           usr_used  [USR_N];
  logic [31:0]  cmd_at    [USR_N][CMD_N];
  logic [19:0]  cmd_len   [USR_N][CMD_N];
  int unsigned  cmd_hd    [USR_N];
  int unsigned  cmd_n     [USR_N];
  logic [23:0]  vol       [USR_N];
  result_t      decisions [$];
  int           err_n;

  function automatic bit aged(logic [31:0] now, logic [31:0] t, logic [31:0] win);
    logic [31:0] d;
    d = now - t;
    return d > win;
  endfunction

  function automatic int unsigned cap(int unsigned v, int unsigned ring);
    return v < ring ? v : ring;
  endfunction

  function automatic int lookup_src(logic [31:0] addr);
    for (int i = 0; i < SRC_N; i++)
      if (src_used[i] && src_tag[i] == addr) return i;
    return -1;
  endfunction

  function automatic bit reusable(int i, logic [31:0] now);
    if (!src_used[i]) return 1;
    if (opens[i] != 0) return 0;
    if (login_n[i] != 0 &&
        !aged(now, login_at[i][(login_hd[i] + login_n[i] - 1) % LOG_N], LOGIN_WINDOW))
      return 0;
    if (kick_n[i] != 0 &&
        !aged(now, kick_at[i][(kick_hd[i] + kick_n[i] - 1) % KICK_N], KICK_WINDOW))
      return 0;
    return 1;
  endfunction

  function automatic int claim_src(logic [31:0] addr, logic [31:0] now);
    int s;
    s = lookup_src(addr);
    if (s >= 0) return s;
    for (int i = 0; i < SRC_N; i++) begin
      if (reusable(i, now)) begin
        src_used[i] = 1;
        src_tag[i]  = addr;
        opens[i]    = 0;
        login_hd[i] = 0;
        login_n[i]  = 0;
        kick_hd[i]  = 0;
        kick_n[i]   = 0;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic int lookup_user(logic [15:0] id);
    for (int i = 0; i < USR_N; i++)
      if (usr_used[i] && usr_tag[i] == id) return i;
    return -1;
  endfunction

  function automatic bit log_kick(logic [31:0] addr, logic [31:0] now);
    int s;
    bit ban;
    s = claim_src(addr, now);
    if (s < 0) return 0;
    while (kick_n[s] > 0 && aged(now, kick_at[s][kick_hd[s]], KICK_WINDOW)) begin
      kick_hd[s] = (kick_hd[s] + 1) % KICK_N;
      kick_n[s]--;
    end
    ban = kick_n[s] >= cap(32'(limits.kick_ban), KICK_N);
    if (kick_n[s] == KICK_N) begin
      kick_hd[s] = (kick_hd[s] + 1) % KICK_N;
      kick_n[s]--;
    end
    kick_at[s][(kick_hd[s] + kick_n[s]) % KICK_N] = now;
    kick_n[s]++;
    return ban;
  endfunction

  function automatic void record_transfer(int u, logic [31:0] now, logic [19:0] len);
    int unsigned k;
    k = (cmd_hd[u] + cmd_n[u]) % CMD_N;
    cmd_at[u][k]  = now;
    cmd_len[u][k] = len;
    cmd_n[u]++;
    vol[u] = vol[u] + 24'(len);
  endfunction

  function automatic result_t decide(item_t it);
    result_t     r;
    int          s;
    int          u;
    int unsigned k;
    logic [31:0] byte_cap;
    r        = '0;
    byte_cap = 32'(limits.max_kb) << KB_SHIFT;
    case (it.action)
      ACT_CONNECT: begin
        s = claim_src(it.source_addr, it.now_seconds);
        if (s < 0) begin
          r.deny_cause = CAUSE_TABLE_FULL;
        end else begin
          while (login_n[s] > 0 &&
                 aged(it.now_seconds, login_at[s][login_hd[s]], LOGIN_WINDOW)) begin
            login_hd[s] = (login_hd[s] + 1) % LOG_N;
            login_n[s]--;
          end
          if (login_n[s] >= cap(32'(limits.max_logins), LOG_N)) begin
            r.deny_cause = CAUSE_LOGIN_RATE;
          end else if (opens[s] >= 32'(limits.max_open)) begin
            r.deny_cause = CAUSE_OPEN_LIMIT;
          end else begin
            login_at[s][(login_hd[s] + login_n[s]) % LOG_N] = it.now_seconds;
            login_n[s]++;
            opens[s]++;
            r.allowed = 1;
          end
        end
      end
      ACT_DISCONNECT: begin
        s = lookup_src(it.source_addr);
        u = lookup_user(it.user_id);
        if (s >= 0 && opens[s] > 0) opens[s]--;
        if (u >= 0) begin
          usr_used[u] = 0;
          cmd_hd[u]   = 0;
          cmd_n[u]    = 0;
          vol[u]      = '0;
        end
        r.allowed = 1;
      end
      ACT_TRANSFER: begin
        u = lookup_user(it.user_id);
        if (u >= 0) begin
          while (cmd_n[u] > 0) begin
            k = cmd_hd[u];
            if (!aged(it.now_seconds, cmd_at[u][k], COMMAND_WINDOW)) break;
            vol[u]    = vol[u] - 24'(cmd_len[u][k]);
            cmd_hd[u] = (cmd_hd[u] + 1) % CMD_N;
            cmd_n[u]--;
          end
          if (cmd_n[u] >= cap(32'(limits.max_cmds), CMD_N))
            r.deny_cause = CAUSE_CMD_COUNT;
          else if (32'(vol[u]) + 32'(it.transfer_bytes) > byte_cap)
            r.deny_cause = CAUSE_BYTE_VOL;
          else begin
            record_transfer(u, it.now_seconds, it.transfer_bytes);
            r.allowed = 1;
          end
        end else if (32'(it.transfer_bytes) > byte_cap) begin
          r.deny_cause = CAUSE_OVERSIZE;
        end else begin
          for (int i = 0; i < USR_N; i++) begin
            if (!usr_used[i]) begin
              u = i;
              break;
            end
          end
          if (u < 0) begin
            r.deny_cause = CAUSE_TABLE_FULL;
          end else begin
            usr_used[u] = 1;
            usr_tag[u]  = it.user_id;
            cmd_hd[u]   = 0;
            cmd_n[u]    = 0;
            vol[u]      = '0;
            record_transfer(u, it.now_seconds, it.transfer_bytes);
            r.allowed = 1;
          end
        end
        if (r.deny_cause inside {CAUSE_CMD_COUNT, CAUSE_BYTE_VOL, CAUSE_OVERSIZE}) begin
          r.kick_user  = 1;
          r.ban_source = log_kick(it.source_addr, it.now_seconds);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void clear_tables();
    limits = '{max_open: RST_MAX_OPEN, max_cmds: RST_MAX_CMDS, max_kb: RST_MAX_KB,
               max_logins: RST_MAX_LOGINS, kick_ban: RST_KICK_BAN};
    for (int i = 0; i < SRC_N; i++) begin
      src_used[i] = 0;
      opens[i]    = 0;
      login_hd[i] = 0;
      login_n[i]  = 0;
      kick_hd[i]  = 0;
      kick_n[i]   = 0;
    end
    for (int i = 0; i < USR_N; i++) begin
      usr_used[i] = 0;
      cmd_hd[i]   = 0;
      cmd_n[i]    = 0;
      vol[i]      = '0;
    end
    decisions.delete();
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_tables();
      err_n = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_OPEN:   limits.max_open   = cfg_data[7:0];
          CFG_MAX_CMDS:   limits.max_cmds   = cfg_data[8:0];
          CFG_MAX_KB:     limits.max_kb     = cfg_data[11:0];
          CFG_MAX_LOGINS: limits.max_logins = cfg_data[5:0];
          CFG_KICK_BAN:   limits.kick_ban   = cfg_data[4:0];
          default: ;
        endcase
      end
      if (push && !full) decisions = {decisions, decide(item)};
      if (pop && !empty) begin
        if (decisions.size() == 0) begin
          $error("result word with no event waiting");
          err_n++;
        end else begin
          want = decisions.pop_front();
          if (result.allowed !== want.allowed) begin
            $error("allowed: expected %0d, got %0d", want.allowed, result.allowed);
            err_n++;
          end
          if (result.deny_cause !== want.deny_cause) begin
            $error("deny_cause: expected %0d, got %0d", want.deny_cause, result.deny_cause);
            err_n++;
          end
          if (result.kick_user !== want.kick_user) begin
            $error("kick_user: expected %0d, got %0d", want.kick_user, result.kick_user);
            err_n++;
          end
          if (result.ban_source !== want.ban_source) begin
            $error("ban_source: expected %0d, got %0d", want.ban_source, result.ban_source);
            err_n++;
          end
        end
      end
    end
    pending <= decisions.size();
    errors  <= err_n;
  end

endmodule

// ===== tb/sv/tb_per_source_sliding_window_limiter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_source_sliding_window_limiter_top
// Drives connect, disconnect and transfer events into the limiter under
// several limit settings, with random idling on both sides, a long result
// stall and a full drain; the checker predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_per_source_sliding_window_limiter_top;
  import slwl_pkg::*;

  localparam int STALL_LIMIT = 40000;

  typedef struct {
    int unsigned open_v, cmds_v, kb_v, logins_v, ban_v;
    int          count;
    bit          wide;
  } phase_t;

  logic                   clk;
  logic                   rst;
  logic                   push;
  item_t                  item;
  logic                   full;
  logic                   pop;
  logic                   empty;
  result_t                result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     errors;
  int                     pending;

  bit          calm;
  int          hold_ticket;
  int          hold_seen;
  int          hold_left;
  int          stall_n;
  logic [31:0] clock_s;
  logic [31:0] addr_pool [8];
  logic [15:0] user_pool [12];
  phase_t      phases [6];

  per_source_sliding_window_limiter_top dut (
    .clk(clk), .rst(rst), .push(push), .item(item), .full(full), .pop(pop),
    .empty(empty), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  slwl_checker chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item), .pop(pop),
    .empty(empty), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors), .pending(pending)
  );

  initial clk = 0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      pop       <= 0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_left > 0) begin
      pop       <= 0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_ticket) begin
      pop       <= 0;
      hold_seen <= hold_ticket;
      hold_left <= 400;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      pop       <= 0;
      hold_left <= $urandom_range(0, 18);
    end else begin
      pop <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_n <= 0;
    end else if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_n <= 0;
    end else if (stall_n >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_n <= stall_n + 1;
    end
  end

  task automatic offer(item_t it);
    item <= it;
    push <= 1;
    do @(posedge clk); while (full);
  endtask

  task automatic rest(int n);
    push <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned v);
    cfg_index <= idx;
    cfg_data  <= v[CFG_DATA_W-1:0];
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic load_limits(phase_t p);
    write_reg(CFG_MAX_OPEN, p.open_v);
    write_reg(CFG_MAX_CMDS, p.cmds_v);
    write_reg(CFG_MAX_KB, p.kb_v);
    write_reg(CFG_MAX_LOGINS, p.logins_v);
    write_reg(CFG_KICK_BAN, p.ban_v);
    @(posedge clk);
  endtask

  function automatic item_t event_word(logic [1:0] act, logic [31:0] addr,
                                       logic [15:0] uid, logic [19:0] len);
    item_t it;
    it.action         = act;
    it.source_addr    = addr;
    it.user_id        = uid;
    it.transfer_bytes = len;
    it.now_seconds    = clock_s;
    return it;
  endfunction

  function automatic item_t random_event(bit wide);
    item_t       it;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) clock_s = $urandom();
    else if (r < 5) clock_s = clock_s + $urandom_range(61, 2000);
    else if (r < 20) clock_s = clock_s + $urandom_range(1, 30);
    else if (r < 45) clock_s = clock_s + 1;
    r = $urandom_range(0, 99);
    if (r < 35) it.action = ACT_CONNECT;
    else if (r < 50) it.action = ACT_DISCONNECT;
    else if (r < 98) it.action = ACT_TRANSFER;
    else it.action = KIND_NONE;
    if ($urandom_range(0, 49) == 0) it.source_addr = $urandom();
    else if (wide) it.source_addr = $urandom_range(0, 199);
    else it.source_addr = addr_pool[$urandom_range(0, 7)];
    if ($urandom_range(0, 49) == 0) it.user_id = 16'($urandom());
    else if (wide) it.user_id = 16'($urandom_range(0, 199));
    else it.user_id = user_pool[$urandom_range(0, 11)];
    r = $urandom_range(0, 99);
    if (r < 5) it.transfer_bytes = 20'($urandom());
    else if (r < 20) it.transfer_bytes = 20'($urandom_range(0, 60000));
    else it.transfer_bytes = 20'($urandom_range(0, 4000));
    it.now_seconds = clock_s;
    return it;
  endfunction

  initial begin
    phases[0] = '{1, 1, 1, 1, 1, 150, 0};
    phases[1] = '{255, 256, 4095, 32, 16, 200, 0};
    phases[2] = '{5, 200, 40, 20, 10, 300, 1};
    phases[3] = '{0, 0, 0, 0, 0, 50, 0};
    phases[4] = '{3, 8, 8, 4, 3, 300, 0};
    phases[5] = '{2, 20, 16, 6, 2, 300, 0};
    foreach (addr_pool[i]) addr_pool[i] = $urandom();
    foreach (user_pool[i]) user_pool[i] = 16'($urandom());
    calm        = 0;
    hold_ticket = 0;
    clock_s     = 0;
    rst         = 1;
    push        = 0;
    item        = '0;
    cfg_valid   = 0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed events under reset limits
    offer(event_word(ACT_CONNECT, 32'h0, 16'h0, 20'h0));
    offer(event_word(ACT_CONNECT, 32'hFFFF_FFFF, 16'hFFFF, 20'hF_FFFF));
    offer(event_word(ACT_TRANSFER, 32'h0, 16'h0, 20'h0));
    offer(event_word(ACT_TRANSFER, 32'hFFFF_FFFF, 16'hFFFF, 20'hF_FFFF));
    offer(event_word(ACT_DISCONNECT, 32'h1234_5678, 16'h4321, 20'h0));
    offer(event_word(KIND_NONE, 32'h0, 16'h0, 20'h0));
    repeat (6) offer(event_word(ACT_CONNECT, 32'h0000_0042, 16'h7, 20'h0));
    offer(event_word(ACT_TRANSFER, 32'h0000_0042, 16'h7, 20'd40000));
    offer(event_word(ACT_TRANSFER, 32'h0000_0042, 16'h7, 20'd2000));
    clock_s = 32'd100;
    offer(event_word(ACT_TRANSFER, 32'h0000_0042, 16'h7, 20'd2000));
    offer(event_word(ACT_DISCONNECT, 32'h0000_0042, 16'h7, 20'h0));
    offer(event_word(ACT_DISCONNECT, 32'h0, 16'h0, 20'h0));
    clock_s = 32'hFFFF_FFF0;
    offer(event_word(ACT_CONNECT, 32'h0000_0042, 16'h7, 20'h0));
    clock_s = 32'd5;
    offer(event_word(ACT_CONNECT, 32'h0000_0042, 16'h7, 20'h0));
    offer(event_word(ACT_TRANSFER, 32'h0000_0042, 16'h9, 20'd40961));
    drain();

    foreach (phases[p]) begin
      load_limits(phases[p]);
      if (p == 5) calm = 1;
      for (int n = 0; n < phases[p].count; n++) begin
        if (p == 1 && n == 100) drain();
        if (p == 4 && n == 20) hold_ticket <= hold_ticket + 1;
        offer(random_event(phases[p].wide));
        if (!calm && $urandom_range(0, 7) == 0) rest($urandom_range(1, 19));
      end
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
